// ----- sv/b64e_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_pkg
// shared types, constants and the sextet to character map of the encoder
// ----------------------------------------------------------------------------
package b64e_pkg;

  localparam int B64E_QUEUE_DEPTH = 2;

  localparam logic [6:0] CHAR_PAD   = 7'h3D;
  localparam logic [6:0] CHAR_PLUS  = 7'h2B;
  localparam logic [6:0] CHAR_SLASH = 7'h2F;

  // one accepted byte, split into the characters it causes
  typedef struct packed {
    logic [3:0][5:0] sextet;
    logic [3:0]      pad;
    logic [1:0]      last_idx;
    logic            eom;
  } b64e_job_t;

  typedef struct packed {
    logic valid;
    logic full;
  } b64e_qstat_t;

  function automatic logic [6:0] b64_char(input logic [5:0] s);
    logic [6:0] c;
    if (s < 6'd26) begin
      c = 7'(s) + 7'd65;
    end else if (s < 6'd52) begin
      c = 7'(s) + 7'd71;
    end else if (s < 6'd62) begin
      c = 7'(s) - 7'd4;
    end else if (s == 6'd62) begin
      c = CHAR_PLUS;
    end else begin
      c = CHAR_SLASH;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- sv/base64_stream_encoder_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// base64_stream_encoder_unit
// base64 encoder, one message byte in, one character out per beat
// ----------------------------------------------------------------------------
// channel | dir | handshake            | payload
// in      | in  | in_valid_i/in_stall_o | data_byte_i, end_of_message_i
// out     | out | out_valid_o/out_stall_i | out_char_o, last_of_run_o, message_done_o
//
// a taken byte is written into a queue slot; its first character then goes to the output register
// the back end emits one character per cycle unless out_stall_i holds it: 1 or 2
// per byte, up to 4 on the final byte, about 1.33 per byte on a long message
// the job queue (QueueDepth entries) lets bytes enter while characters drain
// reset clears phase, queue pointers and count, and the output valid bit at once, no sweep
// out_stall_i holds the output register and backs up into the queue
// ----------------------------------------------------------------------------
module base64_stream_encoder_unit
  import b64e_pkg::*;
#(
  parameter int QueueDepth = B64E_QUEUE_DEPTH
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       end_of_message_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [6:0]      out_char_o,
  output logic            last_of_run_o,
  output logic            message_done_o
);

  b64e_job_t   push_job, head_job;
  b64e_qstat_t qstat;
  logic        push, pop;

  b64e_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .end_of_message_i (end_of_message_i),
    .qstat_i          (qstat),
    .push_o           (push),
    .job_o            (push_job)
  );

  b64e_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .head_o  (head_job),
    .qstat_o (qstat)
  );

  b64e_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head_job),
    .qstat_i        (qstat),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_char_o     (out_char_o),
    .last_of_run_o  (last_of_run_o),
    .message_done_o (message_done_o)
  );

endmodule
`default_nettype wire

// ----- sv/b64e_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_front
// accepts message bytes, tracks the group phase and builds character jobs
// ----------------------------------------------------------------------------
module b64e_front
  import b64e_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_message_i,
  input  wire b64e_qstat_t qstat_i,
  output logic             push_o,
  output b64e_job_t        job_o
);

  localparam logic [1:0] PH0 = 2'd0;
  localparam logic [1:0] PH1 = 2'd1;
  localparam logic [1:0] PH2 = 2'd2;

  logic [1:0] phase_q, phase_d;
  logic [3:0] left_q, left_d;
  logic       accept;

  assign in_stall_o = qstat_i.full;
  assign accept     = in_valid_i && !qstat_i.full;
  assign push_o     = accept;

  always_comb begin
    job_o     = '0;
    job_o.eom = end_of_message_i;
    phase_d   = phase_q;
    left_d    = left_q;
    case (phase_q)
      PH1: begin
        job_o.sextet[0] = {left_q[1:0], data_byte_i[7:4]};
        job_o.sextet[1] = {data_byte_i[3:0], 2'b00};
        job_o.pad[2]    = 1'b1;
        job_o.last_idx  = end_of_message_i ? 2'd2 : 2'd0;
        left_d          = data_byte_i[3:0];
        phase_d         = PH2;
      end
      PH2: begin
        job_o.sextet[0] = {left_q, data_byte_i[7:6]};
        job_o.sextet[1] = data_byte_i[5:0];
        job_o.last_idx  = 2'd1;
        left_d          = 4'd0;
        phase_d         = PH0;
      end
      default: begin
        job_o.sextet[0] = data_byte_i[7:2];
        job_o.sextet[1] = {data_byte_i[1:0], 4'b0000};
        job_o.pad[2]    = 1'b1;
        job_o.pad[3]    = 1'b1;
        job_o.last_idx  = end_of_message_i ? 2'd3 : 2'd0;
        left_d          = {2'b00, data_byte_i[1:0]};
        phase_d         = PH1;
      end
    endcase
    if (end_of_message_i) begin
      left_d  = 4'd0;
      phase_d = PH0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH0;
      left_q  <= 4'd0;
    end else if (accept) begin
      phase_q <= phase_d;
      left_q  <= left_d;
    end
  end

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != 2'd3) else $error("group phase out of range");

  a_phase0_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH0 |-> left_q == 4'd0) else $error("leftover bits at group start");

  a_eom_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && end_of_message_i |=> phase_q == PH0 && left_q == 4'd0)
    else $error("state not cleared after final beat");

endmodule
`default_nettype wire

// ----- sv/b64e_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_queue
// short job queue between the byte front and the character back
// ----------------------------------------------------------------------------
module b64e_queue
  import b64e_pkg::*;
#(
  parameter int Depth = B64E_QUEUE_DEPTH
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire b64e_job_t  job_i,
  input  wire logic       pop_i,
  output b64e_job_t       head_o,
  output b64e_qstat_t     qstat_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  b64e_job_t         slot_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_pop;

  assign qstat_o.valid = count_q != '0;
  assign qstat_o.full  = count_q == CntW'(Depth);
  assign head_o        = slot_q[rd_ptr_q];
  assign do_pop        = pop_i && qstat_o.valid;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !qstat_o.full) else $error("push into full queue");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth)) else $error("queue count out of range");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == '0 |-> wr_ptr_q == rd_ptr_q) else $error("empty queue with split pointers");

endmodule
`default_nettype wire

// ----- sv/b64e_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_back
// walks the head job one character per cycle into the output register unless stalled
// ----------------------------------------------------------------------------
module b64e_back
  import b64e_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire b64e_job_t   head_i,
  input  wire b64e_qstat_t qstat_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [6:0]       out_char_o,
  output logic             last_of_run_o,
  output logic             message_done_o
);

  logic [1:0] idx_q;
  logic       out_valid_q;
  logic [6:0] char_q;
  logic       last_q, done_q;
  logic       advance, at_end;
  logic [6:0] char_d;

  assign advance = qstat_i.valid && (!out_valid_q || !out_stall_i);
  assign at_end  = idx_q == head_i.last_idx;
  assign pop_o   = advance && at_end;
  assign char_d  = head_i.pad[idx_q] ? CHAR_PAD : b64_char(head_i.sextet[idx_q]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        idx_q       <= at_end ? 2'd0 : idx_q + 2'd1;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      char_q <= char_d;
      last_q <= at_end;
      done_q <= at_end && head_i.eom;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_char_o     = char_q;
  assign last_of_run_o  = last_q;
  assign message_done_o = done_q;

  a_idx_in_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat_i.valid |-> idx_q <= head_i.last_idx) else $error("index past job end");

  a_idx_needs_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != 2'd0 |-> qstat_i.valid) else $error("job lost mid run");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && done_q |-> last_q) else $error("message end off run end");

endmodule
`default_nettype wire
